// ===== rtl/shift_insert_array_store_macros.svh =====
// Assertion macros for the shift/insert array store
`ifndef SHIFT_INSERT_ARRAY_STORE_MACROS_SVH
`define SHIFT_INSERT_ARRAY_STORE_MACROS_SVH

`ifndef SYNTHESIS
`define SIAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SIAS_ASSERT_IN_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIAS_ASSERT(lbl, clk, rstn, prop, msg)
`define SIAS_ASSERT_IN_RST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sias_pkg.sv =====
package sias_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned POS_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic  shift_en;
    logic  wr_en;
    pos_t  wr_pos;
    pos_t  rd_pos;
    word_t value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sias_if.sv =====
interface sias_in_if;
  import sias_pkg::*;

  logic  valid;
  logic  ready;
  logic  [1:0] cmd;
  pos_t  position;
  word_t value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface sias_out_if;
  import sias_pkg::*;

  logic  valid;
  logic  ready;
  logic  [1:0] status;
  cnt_t  count_after;
  word_t read_value;

  modport source (output valid, output status, output count_after, output read_value,
                  input ready);
  modport sink   (input valid, input status, input count_after, input read_value,
                  output ready);
endinterface

// ===== rtl/sias_cell.sv =====
module sias_cell (
  input  logic               clk_i,
  input  sias_pkg::pos_t     idx_i,
  input  sias_pkg::cell_ctrl_t ctrl_i,
  input  sias_pkg::word_t    prev_i,
  output sias_pkg::word_t    entry_o,
  output sias_pkg::word_t    rd_o
);
  import sias_pkg::*;

  word_t entry_q;
  word_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en && (idx_i > ctrl_i.wr_pos)) begin
      entry_d = prev_i;
    end else if (ctrl_i.wr_en && (idx_i == ctrl_i.wr_pos)) begin
      entry_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (idx_i == ctrl_i.rd_pos) ? entry_q : '0;

endmodule

// ===== rtl/shift_insert_array_store.sv =====
// Ordered store of DEPTH signed words with a fill count, built as a row of cells.
// Push, pop, insert (shifting later entries up) and read are handled alike:
// an operation is accepted whenever the result register is empty or being
// drained, and its result transaction is presented in the following cycle, so
// one operation per clock is sustained. The whole insert shift happens across
// the cell row on acceptance. Entries need no clearing after reset; only those
// below the count can be read. The capacity register (reset DEPTH, saturating
// at DEPTH) may be written only while no transaction is pending; lowering it
// below the count truncates the count.
`include "shift_insert_array_store_macros.svh"

module shift_insert_array_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  sias_in_if.sink           in_if,
  sias_out_if.source        out_if,
  input  logic              cfg_we_i,
  input  sias_pkg::cnt_t    cfg_data_i
);
  import sias_pkg::*;

  cnt_t       cap_q;
  cnt_t       count_q, count_d;
  cnt_t       lim;
  cnt_t       cfg_lim;
  cnt_t       pos_ext;
  cmd_e       cmd;
  status_e    status_d;
  cell_ctrl_t ctrl;
  logic       in_acc;
  word_t      rd_bus;
  word_t      read_d;
  logic       out_valid_q;
  status_e    status_q;
  cnt_t       count_out_q;
  word_t      read_q;

  word_t entries [DEPTH];
  word_t rd_taps [DEPTH];

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign cmd          = cmd_e'(in_if.cmd);
  assign pos_ext      = CNT_W'(in_if.position);
  assign lim          = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
  assign cfg_lim      = (cfg_data_i > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_data_i;

  always_comb begin
    count_d       = count_q;
    status_d      = ST_OK;
    ctrl          = '0;
    ctrl.value    = in_if.value;
    ctrl.rd_pos   = in_if.position;
    ctrl.wr_pos   = in_if.position;
    unique case (cmd)
      CMD_PUSH: begin
        if (count_q >= lim) begin
          status_d = ST_FULL;
        end else begin
          ctrl.wr_en  = 1'b1;
          ctrl.wr_pos = count_q[POS_W-1:0];
          count_d     = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_ext > count_q) begin
          status_d = ST_RANGE;
        end else if (count_q >= lim) begin
          status_d = ST_FULL;
        end else begin
          ctrl.wr_en    = 1'b1;
          ctrl.shift_en = 1'b1;
          count_d       = count_q + 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_q) begin
          status_d = ST_RANGE;
        end
      end
      default: status_d = ST_OK;
    endcase
    ctrl.wr_en    = ctrl.wr_en && in_acc;
    ctrl.shift_en = ctrl.shift_en && in_acc;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t prev;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = entries[g-1];
    end
    sias_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (POS_W'(g)),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .entry_o (entries[g]),
      .rd_o    (rd_taps[g])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_taps[i];
    end
    read_d = ((cmd == CMD_READ) && (status_d == ST_OK)) ? rd_bus : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CNT_W'(DEPTH);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= cfg_data_i;
        count_q <= (count_q > cfg_lim) ? cfg_lim : count_q;
      end else if (in_acc) begin
        count_q <= count_d;
      end
      out_valid_q <= in_acc || (out_valid_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q    <= status_d;
      count_out_q <= count_d;
      read_q      <= read_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = status_q;
  assign out_if.count_after = count_out_q;
  assign out_if.read_value  = read_q;

  `SIAS_ASSERT(a_count_within_limit, clk_i, rst_ni, count_q <= lim, "count above capacity")
  `SIAS_ASSERT(a_full_at_limit, clk_i, rst_ni, out_valid_q && (status_q == ST_FULL) |-> count_out_q == lim, "full reported below limit")
  `SIAS_ASSERT(a_err_reads_zero, clk_i, rst_ni, out_valid_q && (status_q != ST_OK) |-> read_q == '0, "read value on error")
  `SIAS_ASSERT(a_accept_gives_result, clk_i, rst_ni, in_acc |=> out_valid_q, "accepted transaction lost")
  `SIAS_ASSERT_IN_RST(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_q, "result during reset")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sias_pkg::*;

  typedef struct {
    status_e status;
    cnt_t    count_after;
    word_t   read_value;
  } outcome_t;

  class store_mirror;
    word_t       cells [DEPTH];
    int unsigned fill;
    int unsigned cap;
    outcome_t    awaited[$];
    int unsigned mismatches;
    int unsigned matched;
    int unsigned hits [4];

    function new();
      foreach (cells[i]) cells[i] = '0;
      fill = 0;
      cap  = DEPTH;
      mismatches = 0;
      matched = 0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    function int unsigned limit();
      return (cap > DEPTH) ? DEPTH : cap;
    endfunction

    function void set_capacity(cnt_t v);
      cap = v;
      if (fill > limit()) fill = limit();
    endfunction

    // Works out the outcome of one accepted transaction and queues it
    function void apply_op(cmd_e op, pos_t at, word_t val);
      outcome_t exp;
      exp.status     = ST_OK;
      exp.read_value = '0;
      case (op)
        CMD_PUSH: begin
          if (fill >= limit()) begin
            exp.status = ST_FULL;
          end else begin
            cells[fill] = val;
            fill++;
          end
        end
        CMD_POP: begin
          if (fill == 0) exp.status = ST_EMPTY;
          else fill--;
        end
        CMD_INSERT: begin
          if (at > fill) begin
            exp.status = ST_RANGE;
          end else if (fill >= limit()) begin
            exp.status = ST_FULL;
          end else begin
            for (int unsigned i = fill; i > at; i--) cells[i] = cells[i-1];
            cells[at] = val;
            fill++;
          end
        end
        default: begin
          if (at >= fill) exp.status = ST_RANGE;
          else exp.read_value = cells[at];
        end
      endcase
      exp.count_after = cnt_t'(fill);
      hits[exp.status]++;
      awaited.insert(awaited.size(), exp);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task match_outcome(logic [1:0] status, cnt_t count_after, word_t read_value);
      outcome_t exp;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction st=%0d cnt=%0d rd=%0h",
                                  status, count_after, read_value));
      end else begin
        exp = awaited.pop_front();
        if (status !== exp.status || count_after !== exp.count_after ||
            read_value !== exp.read_value)
          report_mismatch($sformatf("st %0d/%0d cnt %0d/%0d rd %0h/%0h (got/exp)",
                                    status, exp.status, count_after, exp.count_after,
                                    read_value, exp.read_value));
        else
          matched++;
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cnt_t cfg_data_i;

  sias_in_if  in_bus();
  sias_out_if out_bus();

  shift_insert_array_store DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  store_mirror mirror = new();

  int unsigned burst_left = 0;
  int unsigned ops_sent   = 0;
  int unsigned cap_writes = 0;
  int unsigned cap_now    = DEPTH;
  int unsigned est        = 0;
  bit          growing    = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver back-pressure, mode changes every so often
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned cyc;
    out_bus.ready <= 1'b0;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 128);
      repeat (len) begin
        @(posedge clk_i);
        cyc++;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ($urandom_range(0, 7) == 0);
          default: out_bus.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready)
        mirror.match_outcome(out_bus.status, out_bus.count_after, out_bus.read_value);
      if (in_bus.valid && in_bus.ready)
        mirror.apply_op(cmd_e'(in_bus.cmd), in_bus.position, in_bus.value);
    end
  end

  task automatic issue(cmd_e op, pos_t at, word_t val);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(60, 200);
      end else begin
        gap = $urandom_range(0, 7);
        burst_left = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid    <= 1'b1;
    in_bus.cmd      <= op;
    in_bus.position <= at;
    in_bus.value    <= val;
    do @(posedge clk_i); while (!in_bus.ready);
    ops_sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(cnt_t v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    mirror.set_capacity(v);
    cfg_we_i <= 1'b0;
    cap_writes++;
    cap_now = v;
    if (est > mirror.limit()) est = mirror.limit();
  endtask

  task automatic run_phase(int unsigned n_ops);
    cmd_e        op;
    pos_t        at;
    word_t       val;
    int unsigned r;
    int unsigned lim;
    lim = (cap_now > DEPTH) ? DEPTH : cap_now;
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7fff_ffff;
          2: val = -32'sd1;
          default: val = '0;
        endcase
      end else begin
        val = word_t'($urandom());
      end
      at = pos_t'($urandom_range(0, DEPTH - 1));
      if (r < 10) begin
        op = cmd_e'($urandom_range(0, 3));
      end else if (growing ? (r < 45) : (r >= 80)) begin
        op = CMD_PUSH;
      end else if (growing ? (r < 70) : (r < 60)) begin
        op = CMD_INSERT;
        at = pos_t'($urandom_range(0, (est > DEPTH - 1) ? DEPTH - 1 : est));
      end else if (growing ? (r < 85) : (r >= 60)) begin
        op = CMD_READ;
        if (est != 0) at = pos_t'($urandom_range(0, est - 1));
      end else begin
        op = CMD_POP;
      end
      if (!growing && r >= 10 && r < 45) op = CMD_POP;
      issue(op, at, val);
      case (op)
        CMD_PUSH:   if (est < lim) est++;
        CMD_POP:    if (est > 0) est--;
        CMD_INSERT: if (at <= est && est < lim) est++;
        default: ;
      endcase
      if (growing && est >= lim && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && est == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
    end
  endtask

  initial begin
    int unsigned caps [11];
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.cmd      <= CMD_PUSH;
    in_bus.position <= '0;
    in_bus.value    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, bounds and shifting
    issue(CMD_POP,    6'd0,  word_t'($urandom()));
    issue(CMD_READ,   6'd0,  word_t'($urandom()));
    issue(CMD_INSERT, 6'd1,  32'sd5);
    issue(CMD_INSERT, 6'd0,  32'sh8000_0000);
    issue(CMD_PUSH,   6'd63, 32'sh7fff_ffff);
    issue(CMD_PUSH,   6'd0,  -32'sd1);
    issue(CMD_INSERT, 6'd3,  32'sd0);
    issue(CMD_INSERT, 6'd0,  32'sd1);
    issue(CMD_INSERT, 6'd2,  32'sh5a5a_5a5a);
    issue(CMD_READ,   6'd0,  32'sd0);
    issue(CMD_READ,   6'd2,  32'sd0);
    issue(CMD_READ,   6'd5,  32'sd0);
    issue(CMD_READ,   6'd6,  32'sd0);
    issue(CMD_READ,   6'd63, 32'sd0);
    issue(CMD_POP,    6'd0,  32'sd0);
    issue(CMD_INSERT, 6'd7,  32'sd9);
    // truncation, then full and range precedence
    write_capacity(7'd2);
    issue(CMD_PUSH,   6'd0,  32'sd3);
    issue(CMD_INSERT, 6'd3,  32'sd3);
    issue(CMD_INSERT, 6'd2,  32'sd3);
    issue(CMD_READ,   6'd1,  32'sd0);
    // zero capacity
    write_capacity(7'd0);
    issue(CMD_PUSH,   6'd0,  32'sd4);
    issue(CMD_INSERT, 6'd0,  32'sd4);
    issue(CMD_POP,    6'd0,  32'sd0);
    // above DEPTH saturates
    write_capacity(7'd127);
    est = 0;

    caps = '{64, 1, 127, 0, 0, 64, 2, 0, 100, 64, 3};
    caps[3] = $urandom_range(1, DEPTH);
    caps[7] = $urandom_range(1, DEPTH);
    foreach (caps[i]) begin
      write_capacity(cnt_t'(caps[i]));
      run_phase(150);
    end

    drain();
    $display("%0d operations over %0d capacity settings, %0d results checked",
             ops_sent, cap_writes, mirror.matched + mirror.mismatches);
    $display("outcomes: ok %0d, full %0d, out of range %0d, empty %0d",
             mirror.hits[ST_OK], mirror.hits[ST_FULL], mirror.hits[ST_RANGE],
             mirror.hits[ST_EMPTY]);
    if (mirror.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
